/* hdl/satq_pkg.sv */
// Package for the sorted alarm timer queue: field widths, input kind codes,
// the list entry type and the sequencer state type.
// No dependencies; every other file of the block imports it.
package satq_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W  = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 5;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0] expire;
    logic [ID_W-1:0]   handle;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_WRITE,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_FIRE_RD,
    ST_FIRE_CHK
  } state_t;

endpackage

/* hdl/satq_if.sv */
// Handshake channels of the sorted alarm timer queue: the command channel
// and the result channel. Depends on satq_pkg for the field widths.
interface satq_cmd_if;
  import satq_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [ID_W-1:0]    alarm_id;
  logic [DELAY_W-1:0] delay_secs;

  modport source (output valid, kind, alarm_id, delay_secs, input ready);
  modport sink   (input valid, kind, alarm_id, delay_secs, output ready);
endinterface

interface satq_res_if;
  import satq_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic              fired;
  logic [ID_W-1:0]   fired_id;
  logic [CNT_W-1:0]  pending_count;
  logic              next_valid;
  logic [TIME_W-1:0] next_expire;
  logic              last;

  modport source (output valid, status, fired, fired_id, pending_count, next_valid,
                  next_expire, last, input ready);
  modport sink   (input valid, status, fired, fired_id, pending_count, next_valid,
                  next_expire, last, output ready);
endinterface

/* hdl/sorted_alarm_timer_queue_unit.sv */
// Top level of the sorted alarm timer queue: the sequencer and the list
// memory. Uses satq_pkg, satq_if, satq_mem and satq_ctrl.
//
//   Channel  Direction  Handshake      Item
//   cmd      in         valid / ready  kind, alarm_id, delay_secs
//   res      out        valid / ready  status, fired, fired_id, pending_count,
//                                      next_valid, next_expire, last
//
// One item at a time: cmd.ready is high only while the sequencer is idle. An add or a
// delete scans the list and shifts entries to open or close a place for the alarm; a tick
// examines alarms from the head and then shifts the rest down over the fired ones.
// Reset clears the counter, the list length and the handshakes, not the memory.
// A result waits in the output register while res.ready is low, and the
// sequencer stalls at its next result.
module sorted_alarm_timer_queue_unit #(
  parameter int CAPACITY = satq_pkg::CAPACITY_DEF
) (
  input logic         clk,
  input logic         rst,
  satq_cmd_if.sink    cmd,
  satq_res_if.source  res
);
  import satq_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  satq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .res     (res),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  satq_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

/* hdl/satq_mem.sv */
// List memory of the alarm queue: one write port and one read port with a
// registered read that holds its data while no read is issued. Uses satq_pkg.
module satq_mem #(
  parameter int DEPTH = satq_pkg::CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output satq_pkg::entry_t         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  satq_pkg::entry_t         wr_data
);
  import satq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/satq_ctrl.sv */
// Sequencer of the alarm queue: seconds counter, list length, the scan, shift
// and fire walks over the list memory, and the result register.
// Uses satq_pkg and the channel interfaces of satq_if.
module satq_ctrl #(
  parameter int CAPACITY = satq_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  satq_cmd_if.sink                    cmd,
  satq_res_if.source                  res,
  output logic                        rd_en,
  output logic [$clog2(CAPACITY)-1:0] rd_addr,
  input  satq_pkg::entry_t            rd_data,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output satq_pkg::entry_t            wr_data
);
  import satq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_t             state, state_next;
  logic [TIME_W-1:0]  clock_s, clock_s_next;
  logic [CW-1:0]      count, count_next;
  logic [KIND_W-1:0]  op, op_next;
  logic [ID_W-1:0]    id, id_next;
  logic [DELAY_W-1:0] key, key_next;
  logic               found, found_next;
  logic               stopped, stopped_next;
  logic               full, full_next;
  logic [IW-1:0]      p, p_next;
  logic [CW-1:0]      q, q_next;
  logic [CW-1:0]      issue, issue_next;
  logic               rv, rv_next;
  logic [IW-1:0]      tag, tag_next;
  logic               mv_up, mv_up_next;
  logic [IW-1:0]      mv_src, mv_src_next;
  logic [IW-1:0]      mv_dst, mv_dst_next;
  logic [CW-1:0]      mv_left, mv_left_next;
  logic [CW-1:0]      fi, fi_next;
  logic [CW-1:0]      k, k_next;
  logic               pf_valid, pf_valid_next;
  logic [ID_W-1:0]    pf_id, pf_id_next;

  logic               o_valid;
  logic               o_status;
  logic               o_fired;
  logic [ID_W-1:0]    o_fid;
  logic [CNT_W-1:0]   o_pend;
  logic               o_nv;
  logic [TIME_W-1:0]  o_next;
  logic               o_last;

  logic               emit;
  logic               e_status;
  logic               e_fired;
  logic [ID_W-1:0]    e_fid;
  logic [CW-1:0]      e_pend;
  logic               e_nv;
  logic [TIME_W-1:0]  e_next;
  logic               e_last;

  logic               can_emit;
  logic [TIME_W-1:0]  ahead;
  logic [TIME_W-1:0]  age;
  logic               in_range;
  logic               expired;

  assign can_emit = !o_valid || res.ready;
  // Distance of the entry just read from now, and how long ago it expired.
  assign ahead    = rd_data.expire - clock_s;
  assign age      = clock_s - rd_data.expire;
  assign in_range = ahead <= TIME_W'(key);
  assign expired  = !age[TIME_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_s  <= '0;
      count    <= '0;
      rv       <= 1'b0;
      pf_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      clock_s  <= clock_s_next;
      count    <= count_next;
      rv       <= rv_next;
      pf_valid <= pf_valid_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    id      <= id_next;
    key     <= key_next;
    found   <= found_next;
    stopped <= stopped_next;
    full    <= full_next;
    p       <= p_next;
    q       <= q_next;
    issue   <= issue_next;
    tag     <= tag_next;
    mv_up   <= mv_up_next;
    mv_src  <= mv_src_next;
    mv_dst  <= mv_dst_next;
    mv_left <= mv_left_next;
    fi      <= fi_next;
    k       <= k_next;
    pf_id   <= pf_id_next;
    if (emit) begin
      o_status <= e_status;
      o_fired  <= e_fired;
      o_fid    <= e_fid;
      o_pend   <= CNT_W'(e_pend);
      o_nv     <= e_nv;
      o_next   <= e_next;
      o_last   <= e_last;
    end
  end

  always_comb begin
    state_next    = state;
    clock_s_next  = clock_s;
    count_next    = count;
    op_next       = op;
    id_next       = id;
    key_next      = key;
    found_next    = found;
    stopped_next  = stopped;
    full_next     = full;
    p_next        = p;
    q_next        = q;
    issue_next    = issue;
    rv_next       = rv;
    tag_next      = tag;
    mv_up_next    = mv_up;
    mv_src_next   = mv_src;
    mv_dst_next   = mv_dst;
    mv_left_next  = mv_left;
    fi_next       = fi;
    k_next        = k;
    pf_valid_next = pf_valid;
    pf_id_next    = pf_id;
    cmd.ready     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    emit          = 1'b0;
    e_status      = STATUS_OK;
    e_fired       = 1'b0;
    e_fid         = '0;
    e_pend        = count;
    e_nv          = 1'b0;
    e_next        = '0;
    e_last        = 1'b1;

    case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          op_next       = cmd.kind;
          id_next       = cmd.alarm_id;
          key_next      = cmd.delay_secs;
          found_next    = 1'b0;
          stopped_next  = 1'b0;
          full_next     = 1'b0;
          q_next        = '0;
          issue_next    = '0;
          rv_next       = 1'b0;
          fi_next       = '0;
          pf_valid_next = 1'b0;
          case (cmd.kind)
            KIND_ADD, KIND_DEL: begin
              state_next = ST_SCAN;
            end
            KIND_TICK: begin
              clock_s_next = clock_s + 1'b1;
              state_next   = ST_FIRE_RD;
            end
            default: begin
              state_next = ST_HEAD_RD;
            end
          endcase
        end
      end

      // One read issued per cycle; the entry read in the previous cycle is
      // checked for the handle and for the insertion point of an add.
      ST_SCAN: begin
        if (issue < count) begin
          rd_en      = 1'b1;
          rd_addr    = issue[IW-1:0];
          issue_next = issue + 1'b1;
          rv_next    = 1'b1;
          tag_next   = issue[IW-1:0];
        end else begin
          rv_next = 1'b0;
        end
        if (rv) begin
          if (rd_data.handle == id && !found) begin
            found_next = 1'b1;
            p_next     = tag;
          end else if (!stopped) begin
            if (in_range) begin
              q_next = q + 1'b1;
            end else begin
              stopped_next = 1'b1;
            end
          end
        end
        if (issue == count && !rv) begin
          if (op == KIND_DEL) begin
            if (found) begin
              mv_up_next   = 1'b0;
              mv_src_next  = p + 1'b1;
              mv_dst_next  = p;
              mv_left_next = count - CW'(p) - 1'b1;
              state_next   = ST_MOVE;
            end else begin
              state_next = ST_HEAD_RD;
            end
          end else if (found) begin
            // The alarm moves within the list: only the entries between its
            // old and its new place shift by one.
            mv_dst_next = p;
            state_next  = ST_MOVE;
            if (q < CW'(p)) begin
              mv_up_next   = 1'b1;
              mv_src_next  = p - 1'b1;
              mv_left_next = CW'(p) - q;
            end else begin
              mv_up_next   = 1'b0;
              mv_src_next  = p + 1'b1;
              mv_left_next = q - CW'(p);
            end
          end else if (count == CAP_CNT) begin
            full_next  = 1'b1;
            state_next = ST_HEAD_RD;
          end else begin
            mv_up_next   = 1'b1;
            mv_src_next  = IW'(count - 1'b1);
            mv_dst_next  = IW'(count);
            mv_left_next = count - q;
            state_next   = ST_MOVE;
          end
        end
      end

      // Read at the source and write the data in the next cycle at the
      // destination; the two addresses never meet in the same cycle.
      ST_MOVE: begin
        if (mv_left != '0) begin
          rd_en        = 1'b1;
          rd_addr      = mv_src;
          mv_src_next  = mv_up ? mv_src - 1'b1 : mv_src + 1'b1;
          mv_dst_next  = mv_up ? mv_dst - 1'b1 : mv_dst + 1'b1;
          mv_left_next = mv_left - 1'b1;
          rv_next      = 1'b1;
          tag_next     = mv_dst;
        end else begin
          rv_next = 1'b0;
        end
        if (rv) begin
          wr_en   = 1'b1;
          wr_addr = tag;
          wr_data = rd_data;
        end
        if (mv_left == '0 && !rv) begin
          case (op)
            KIND_ADD: begin
              state_next = ST_WRITE;
            end
            KIND_DEL: begin
              count_next = count - 1'b1;
              state_next = ST_HEAD_RD;
            end
            default: begin
              count_next = count - k;
              state_next = ST_IDLE;
            end
          endcase
        end
      end

      ST_WRITE: begin
        wr_en          = 1'b1;
        wr_addr        = q[IW-1:0];
        wr_data.expire = clock_s + TIME_W'(key);
        wr_data.handle = id;
        if (!found) begin
          count_next = count + 1'b1;
        end
        state_next = ST_HEAD_RD;
      end

      ST_HEAD_RD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = ST_HEAD_CHK;
      end

      ST_HEAD_CHK: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_status   = full;
          e_nv       = count != '0;
          e_next     = (count != '0) ? rd_data.expire : '0;
          state_next = ST_IDLE;
        end
      end

      ST_FIRE_RD: begin
        if (fi < count) begin
          rd_en      = 1'b1;
          rd_addr    = fi[IW-1:0];
          state_next = ST_FIRE_CHK;
        end else if (can_emit) begin
          // End of the list: either it was empty or every alarm fired.
          emit       = 1'b1;
          e_fired    = pf_valid;
          e_fid      = pf_valid ? pf_id : '0;
          e_pend     = '0;
          count_next = '0;
          state_next = ST_IDLE;
        end
      end

      // The result for the alarm fired before is held back until the next
      // entry is known, since that entry gives its next expiry and last mark.
      ST_FIRE_CHK: begin
        if (!(pf_valid || !expired) || can_emit) begin
          if (pf_valid) begin
            emit    = 1'b1;
            e_fired = 1'b1;
            e_fid   = pf_id;
            e_pend  = count - fi;
            e_nv    = 1'b1;
            e_next  = rd_data.expire;
            e_last  = !expired;
          end else if (!expired) begin
            emit   = 1'b1;
            e_nv   = 1'b1;
            e_next = rd_data.expire;
          end
          if (expired) begin
            pf_valid_next = 1'b1;
            pf_id_next    = rd_data.handle;
            fi_next       = fi + 1'b1;
            state_next    = ST_FIRE_RD;
          end else if (pf_valid) begin
            k_next       = fi;
            mv_up_next   = 1'b0;
            mv_src_next  = fi[IW-1:0];
            mv_dst_next  = '0;
            mv_left_next = count - fi;
            rv_next      = 1'b0;
            state_next   = ST_MOVE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res.valid         = o_valid;
  assign res.status        = o_status;
  assign res.fired         = o_fired;
  assign res.fired_id      = o_fid;
  assign res.pending_count = o_pend;
  assign res.next_valid    = o_nv;
  assign res.next_expire   = o_next;
  assign res.last          = o_last;

endmodule
